// ===== src/oahm_pkg.sv =====
// ----------------------------------------------------------------------------
// oahm_pkg
// Shared types and constants of the open-addressed hash map.
// ----------------------------------------------------------------------------
`default_nettype none

package oahm_pkg;

  // Port field widths
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned REF_W    = 32;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;
  localparam int unsigned MIN_LOG2       = 2;
  localparam int unsigned PROBE_EXTRA    = 8;
  localparam int unsigned PERTURB_SHIFT  = 5;

  // Request kind
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK
  } ctrl_state_e;

  typedef struct packed {
    logic load;      // latch request, start probe
    logic step;      // advance to next probe slot
    logic emit;      // register result, commit insert
    logic clear_en;  // clearing pass write
    logic cfg_load;  // new slot count, restart clear
  } oahm_cmd_t;

  typedef struct packed {
    logic done;      // current probe settles the request
    logic clr_last;  // clearing pass at last slot
  } oahm_stat_t;

endpackage

`default_nettype wire

// ===== src/oahm_ctrl.sv =====
// ----------------------------------------------------------------------------
// oahm_ctrl
// Controller: request/result handshakes, clearing pass and probe sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module oahm_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  output oahm_pkg::oahm_cmd_t     cmd_o,
  input  wire oahm_pkg::oahm_stat_t stat_i
);
  import oahm_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = !cfg_valid_i;
        if (in_valid_i && !cfg_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat_i.done) begin
          // hold the probe until the result register frees up
          if (out_free) begin
            cmd_o.emit = 1'b1;
            state_d    = ST_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: state_d = ST_CLEAR;
    endcase

    if (cfg_valid_i) begin
      cmd_o.cfg_load = 1'b1;
      state_d        = ST_CLEAR;
    end
  end

  assign out_valid_d = cmd_o.emit || (out_valid_q && !out_ready_i);

endmodule

`default_nettype wire

// ===== src/oahm_datapath.sv =====
// ----------------------------------------------------------------------------
// oahm_datapath
// Slot memory, probe address generator, key compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module oahm_datapath #(
  parameter int unsigned MAX_SLOTS = 256,
  parameter int unsigned KEY_BITS  = 64,
  parameter int unsigned REF_BITS  = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire oahm_pkg::oahm_cmd_t              cmd_i,
  output oahm_pkg::oahm_stat_t                  stat_o,
  input  wire logic [oahm_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire logic                             mode_i,
  input  wire logic [oahm_pkg::KEY_W-1:0]       key_i,
  input  wire logic [oahm_pkg::HASH_W-1:0]      hash_i,
  input  wire logic [oahm_pkg::REF_W-1:0]       member_i,
  output logic [oahm_pkg::STATUS_W-1:0]         status_o,
  output logic [oahm_pkg::REF_W-1:0]            member_o,
  output logic [oahm_pkg::INDEX_W-1:0]          index_o
);
  import oahm_pkg::*;

  localparam int unsigned SLOT_W    = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W     = SLOT_W + 2;
  localparam int unsigned ENT_W     = SLOT_W + 1;
  localparam int unsigned ENTRY_W   = 1 + KEY_BITS + REF_BITS + INDEX_W;
  localparam int unsigned REF_IN_W  = (REF_BITS < REF_W) ? REF_BITS : REF_W;
  localparam int unsigned NUM_IN_W  = (ENT_W < INDEX_W) ? ENT_W : INDEX_W;
  localparam int unsigned NUM_LSB   = 0;
  localparam int unsigned REF_LSB   = INDEX_W;
  localparam int unsigned KEY_LSB   = INDEX_W + REF_BITS;
  localparam int unsigned USED_BIT  = ENTRY_W - 1;

  logic [ENTRY_W-1:0]  mem [MAX_SLOTS];

  logic [CFG_W-1:0]    cfg_q;
  logic [ENT_W-1:0]    entry_q;
  logic [SLOT_W-1:0]   clr_q;
  logic                mode_q;
  logic                full_q;
  logic [KEY_BITS-1:0] key_q;
  logic [REF_BITS-1:0] ref_q;
  logic [HASH_W-1:0]   hash_q;
  logic [SLOT_W-1:0]   bucket_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [ENTRY_W-1:0]  rd_q;

  logic [4:0]          lg_ext;
  logic [4:0]          lg_eff;
  logic [SLOT_W:0]     slots;
  logic [SLOT_W-1:0]   slot_mask;
  logic [CNT_W-1:0]    bound_m1;
  logic [CNT_W-1:0]    entry_inc;
  logic [CNT_W+1:0]    load_lhs;
  logic [CNT_W+1:0]    load_rhs;
  logic                table_full;
  logic [SLOT_W-1:0]   bucket_nxt;
  logic [SLOT_W-1:0]   rd_addr;
  logic [REF_BITS-1:0] ref_in;
  logic [INDEX_W-1:0]  entry_idx;

  logic                rd_used;
  logic                key_hit;
  logic                last_probe;
  logic                done;
  logic                wr_insert;
  logic [STATUS_W-1:0] res_status;
  logic [REF_W-1:0]    res_member;
  logic [INDEX_W-1:0]  res_index;

  logic                wr_en;
  logic [SLOT_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0]  wr_data;

  // Active slot count and mask, log2 clamped to [MIN_LOG2, SLOT_W]
  always_comb begin
    lg_ext = {1'b0, cfg_q};
    if (lg_ext < 5'(MIN_LOG2)) begin
      lg_eff = 5'(MIN_LOG2);
    end else if (lg_ext > 5'(SLOT_W)) begin
      lg_eff = 5'(SLOT_W);
    end else begin
      lg_eff = lg_ext;
    end
  end

  assign slots     = (SLOT_W + 1)'(1) << lg_eff;
  assign slot_mask = slots[SLOT_W-1:0] - SLOT_W'(1);

  // Load limit: (entries + 1) * 4 > slots * 3
  assign entry_inc  = {1'b0, entry_q} + CNT_W'(1);
  assign load_lhs   = {entry_inc, 2'b00};
  assign load_rhs   = {2'b00, slots, 1'b0} + {3'b000, slots};
  assign table_full = load_lhs > load_rhs;

  assign bound_m1 = (mode_q == MODE_LOOKUP) ? ({1'b0, slots} - CNT_W'(1))
                                            : ({1'b0, slots} + CNT_W'(PROBE_EXTRA - 1));

  // Python-style probe: 5*b + perturb + 1
  assign bucket_nxt = ((bucket_q << 2) + bucket_q + hash_q[SLOT_W-1:0] + SLOT_W'(1))
                      & slot_mask;
  assign rd_addr    = cmd_i.step ? bucket_nxt : bucket_q;

  always_comb begin
    ref_in = '0;
    ref_in[REF_IN_W-1:0] = member_i[REF_IN_W-1:0];
    entry_idx = '0;
    entry_idx[NUM_IN_W-1:0] = entry_q[NUM_IN_W-1:0];
  end

  assign rd_used    = rd_q[USED_BIT];
  assign key_hit    = rd_q[KEY_LSB +: KEY_BITS] == key_q;
  assign last_probe = cnt_q == bound_m1;

  always_comb begin
    done       = 1'b1;
    wr_insert  = 1'b0;
    res_status = STATUS_NOT_FOUND;
    res_member = '0;
    res_index  = '0;
    priority if (full_q) begin
      res_status = STATUS_FULL;
    end else if (!rd_used) begin
      if (mode_q == MODE_INSERT) begin
        wr_insert  = 1'b1;
        res_status = STATUS_OK;
        res_index  = entry_idx;
      end
    end else if (mode_q == MODE_LOOKUP && key_hit) begin
      res_status = STATUS_OK;
      res_member[REF_IN_W-1:0] = rd_q[REF_LSB +: REF_IN_W];
      res_index  = rd_q[NUM_LSB +: INDEX_W];
    end else if (last_probe) begin
      res_status = (mode_q == MODE_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
    end else begin
      done = 1'b0;
    end
  end

  assign stat_o.done     = done;
  assign stat_o.clr_last = clr_q == SLOT_W'(MAX_SLOTS - 1);

  // Single write port shared by the clearing pass and inserts
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = bucket_q;
    wr_data = {1'b1, key_q, ref_q, entry_idx};
    if (cmd_i.clear_en) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = '0;
    end else if (cmd_i.emit && wr_insert) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= CFG_RESET;
      entry_q <= '0;
      clr_q   <= '0;
    end else begin
      if (cmd_i.cfg_load) begin
        cfg_q   <= cfg_data_i;
        entry_q <= '0;
        clr_q   <= '0;
      end else begin
        if (cmd_i.clear_en) begin
          clr_q <= clr_q + SLOT_W'(1);
        end
        if (cmd_i.emit && wr_insert) begin
          entry_q <= entry_q + ENT_W'(1);
        end
      end
    end
  end

  // Request and probe state
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q   <= mode_i;
      full_q   <= (mode_i == MODE_INSERT) && table_full;
      key_q    <= key_i[KEY_BITS-1:0];
      ref_q    <= ref_in;
      hash_q   <= hash_i;
      bucket_q <= hash_i[SLOT_W-1:0] & slot_mask;
      cnt_q    <= '0;
    end else if (cmd_i.step) begin
      hash_q   <= hash_q >> PERTURB_SHIFT;
      bucket_q <= bucket_nxt;
      cnt_q    <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_o <= res_status;
      member_o <= res_member;
      index_o  <= res_index;
    end
  end

endmodule

`default_nettype wire

// ===== src/open_address_hash_map.sv =====
// ----------------------------------------------------------------------------
// open_address_hash_map
// Open-addressed hash map with power-of-two table and perturbed probing.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser selects insert (0) or lookup
// (1), tdata carries key id, key hash and member reference. One result per
// request leaves on m_axis: tuser is the status, tdata the member and index.
// The slot count is written on the cfg channel; each write empties the table.
// After acceptance a request passes through the READ and CHECK states; every
// further probe stays in CHECK, and m_axis_tvalid rises once the result is
// registered. The slot memory is read once per cycle, and the next request
// is taken in the cycle after the result is registered. A result waiting in
// the output register does not block the next request; it stalls only the
// following result, and the probe holds in place until the register frees
// up.
// After reset, and after every cfg write, a clearing pass runs through all
// MAX_SLOTS slots, one per cycle, during which s_axis_tready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module open_address_hash_map #(
  parameter int unsigned MAX_SLOTS = 256,
  parameter int unsigned KEY_BITS  = 64,
  parameter int unsigned REF_BITS  = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [63:0] key_id, [95:64] key_hash, [127:96] member_ref
  input  wire logic [127:0]                  s_axis_tdata,
  // [0] mode
  input  wire logic                          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [31:0] found_member, [39:32] found_index
  output logic [39:0]                        m_axis_tdata,
  // [1:0] status
  output logic [oahm_pkg::STATUS_W-1:0]      m_axis_tuser,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [oahm_pkg::CFG_W-1:0]    cfg_data_i
);
  import oahm_pkg::*;

  oahm_cmd_t           cmd;
  oahm_stat_t          stat;
  logic [REF_W-1:0]    found_member;
  logic [INDEX_W-1:0]  found_index;

  oahm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  oahm_datapath #(
    .MAX_SLOTS (MAX_SLOTS),
    .KEY_BITS  (KEY_BITS),
    .REF_BITS  (REF_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_data_i (cfg_data_i),
    .mode_i     (s_axis_tuser),
    .key_i      (s_axis_tdata[63:0]),
    .hash_i     (s_axis_tdata[95:64]),
    .member_i   (s_axis_tdata[127:96]),
    .status_o   (m_axis_tuser),
    .member_o   (found_member),
    .index_o    (found_index)
  );

  assign m_axis_tdata = {found_index, found_member};

endmodule

`default_nettype wire
